[rtl/ssmds_pkg.sv]
// Package for the seven-segment mode display scanner.
// Holds segment codes, display mode codes and constant-divisor helpers.
// No dependencies.
package ssmds_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int VAL_W      = 14;

    localparam logic [7:0] SEG_BLANK    = 8'hFF;
    localparam logic [7:0] SEG_LETTER_C = 8'hC6;
    localparam logic [7:0] SEG_LETTER_P = 8'h8C;
    localparam logic [7:0] SEG_DP_MASK  = 8'h7F;
    localparam logic [7:0] LED_ALL_OFF  = 8'hFF;

    typedef enum logic [1:0] {
        MODE_TEMP  = 2'd0,
        MODE_PARAM = 2'd1,
        MODE_DAC   = 2'd2,
        MODE_KEEP  = 2'd3
    } mode_t;

    typedef logic [NUM_DIGITS-1:0][7:0] digit_buf_t;

    // Active-low segments for a decimal digit.
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Reciprocal-multiply quotients, exact for any 14-bit value.
    function automatic logic [VAL_W-1:0] div10(input logic [VAL_W-1:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd52429;
        return p[32:19];
    endfunction

    function automatic logic [VAL_W-1:0] div100(input logic [VAL_W-1:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd5243;
        return p[32:19];
    endfunction

    function automatic logic [VAL_W-1:0] div1000(input logic [VAL_W-1:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd8389;
        return VAL_W'(p[32:23]);
    endfunction

    function automatic logic [3:0] mod10(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] q;
        logic [VAL_W-1:0] r;
        q = div10(x);
        r = x - VAL_W'(q * VAL_W'(10));
        return r[3:0];
    endfunction

endpackage

[rtl/seven_segment_mode_display_scanner.sv]
// Pipeline: request register, then result register; the result register loads from
// the request register once the result register is empty or being taken.
// Throughput: one request per cycle while the result side does not stall.
// Reset (rst_n low, async): scan index to 0, digit buffer to all blank (0xFF),
// both pipeline stages empty. Depends on ssmds_pkg.
module seven_segment_mode_display_scanner (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [13:0] temperature,
    input  logic [6:0]  setpoint,
    input  logic [13:0] dac_millivolts,
    input  logic [1:0]  display_mode,
    input  logic        dac_follows_mode,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  digit_enable,
    output logic [7:0]  segments,
    output logic [7:0]  status_leds
);

    localparam int VW = ssmds_pkg::VAL_W;

    // Handshake control. The result register empties or is taken -> pipe moves.
    logic advance;
    logic in_fire;
    logic s2_load;

    // Stage 1: request register. Quotients by 10/100/1000 are formed ahead of
    // it so the second stage only needs the mod-10 and the segment lookup.
    logic            s1_valid_reg, s1_valid_next;
    logic [VW-1:0]   t_q0_reg, t_q1_reg, t_q2_reg, t_q3_reg;
    logic [VW-1:0]   sp_q0_reg, sp_q1_reg;
    logic [VW-1:0]   dac_q1_reg, dac_q2_reg, dac_q3_reg;
    ssmds_pkg::mode_t mode_reg;
    logic            flag_reg;

    // Stage 2: display state and result register.
    logic [ssmds_pkg::IDX_W-1:0] scan_index_reg, scan_index_next;
    ssmds_pkg::digit_buf_t       buf_reg, buf_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  digit_enable_reg, segments_reg, status_leds_reg;
    logic [7:0]                  leds_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;
    assign s2_load  = s1_valid_reg && advance;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s2_load)
            out_valid_next = 1'b1;
        else if (advance)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            t_q0_reg   <= temperature;
            t_q1_reg   <= ssmds_pkg::div10(temperature);
            t_q2_reg   <= ssmds_pkg::div100(temperature);
            t_q3_reg   <= ssmds_pkg::div1000(temperature);
            sp_q0_reg  <= VW'(setpoint);
            sp_q1_reg  <= ssmds_pkg::div10(VW'(setpoint));
            dac_q1_reg <= ssmds_pkg::div10(dac_millivolts);
            dac_q2_reg <= ssmds_pkg::div100(dac_millivolts);
            dac_q3_reg <= ssmds_pkg::div1000(dac_millivolts);
            mode_reg   <= ssmds_pkg::mode_t'(display_mode);
            flag_reg   <= dac_follows_mode;
        end
    end

    // Buffer rewrite. Digit 0 is the leading letter; unused digits blank.
    // Keep mode leaves the buffer as it was.
    always_comb
    begin
        buf_next = {ssmds_pkg::NUM_DIGITS{ssmds_pkg::SEG_BLANK}};
        unique case (mode_reg)
            ssmds_pkg::MODE_TEMP:
            begin
                buf_next[0] = ssmds_pkg::SEG_LETTER_C;
                buf_next[4] = ssmds_pkg::seg_of(ssmds_pkg::mod10(t_q3_reg));
                buf_next[5] = ssmds_pkg::seg_of(ssmds_pkg::mod10(t_q2_reg))
                              & ssmds_pkg::SEG_DP_MASK;
                buf_next[6] = ssmds_pkg::seg_of(ssmds_pkg::mod10(t_q1_reg));
                buf_next[7] = ssmds_pkg::seg_of(ssmds_pkg::mod10(t_q0_reg));
            end
            ssmds_pkg::MODE_PARAM:
            begin
                buf_next[0] = ssmds_pkg::SEG_LETTER_P;
                buf_next[6] = ssmds_pkg::seg_of(ssmds_pkg::mod10(sp_q1_reg));
                buf_next[7] = ssmds_pkg::seg_of(ssmds_pkg::mod10(sp_q0_reg));
            end
            ssmds_pkg::MODE_DAC:
            begin
                // volts with decimal point, then tenths and hundredths
                buf_next[0] = ssmds_pkg::SEG_LETTER_P;
                buf_next[5] = ssmds_pkg::seg_of(ssmds_pkg::mod10(dac_q3_reg))
                              & ssmds_pkg::SEG_DP_MASK;
                buf_next[6] = ssmds_pkg::seg_of(ssmds_pkg::mod10(dac_q2_reg));
                buf_next[7] = ssmds_pkg::seg_of(ssmds_pkg::mod10(dac_q1_reg));
            end
            ssmds_pkg::MODE_KEEP:
            begin
                buf_next = buf_reg;
            end
            default:
            begin
                buf_next = buf_reg;
            end
        endcase
    end

    // Active-low status LEDs: bit 0 for DAC flag clear, bits 1..3 per mode.
    always_comb
    begin
        leds_next = ssmds_pkg::LED_ALL_OFF;
        if (!flag_reg)
            leds_next[0] = 1'b0;
        unique case (mode_reg)
            ssmds_pkg::MODE_TEMP:  leds_next[1] = 1'b0;
            ssmds_pkg::MODE_PARAM: leds_next[2] = 1'b0;
            ssmds_pkg::MODE_DAC:   leds_next[3] = 1'b0;
            ssmds_pkg::MODE_KEEP:  leds_next[3] = 1'b1;
            default:               leds_next[3] = 1'b1;
        endcase
    end

    assign scan_index_next = scan_index_reg + 1'b1;   // wraps 7 -> 0

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_index_reg <= '0;
            buf_reg        <= {ssmds_pkg::NUM_DIGITS{ssmds_pkg::SEG_BLANK}};
        end
        else if (s2_load)
        begin
            scan_index_reg <= scan_index_next;
            buf_reg        <= buf_next;
        end
    end

    // Result register: scanned digit read from the freshly written buffer.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            digit_enable_reg <= 8'b1 << scan_index_reg;
            segments_reg     <= buf_next[scan_index_reg];
            status_leds_reg  <= leds_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_enable = digit_enable_reg;
    assign segments     = segments_reg;
    assign status_leds  = status_leds_reg;

endmodule

[rtl/ssmds_checker.sv]
// Port-level checker for seven_segment_mode_display_scanner, bound to the top.
// Depends on the top level's ports only.
module ssmds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] digit_enable,
    input logic [7:0] segments,
    input logic [7:0] status_leds
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit_enable)
            && $stable(segments) && $stable(status_leds))
        else $error("stalled result changed");

    // request side backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled while result side free");

    a_onehot_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(digit_enable))
        else $error("digit select not one-hot");

    // at most one mode LED lit, upper LEDs dark
    a_leds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(~status_leds[3:1]) && (status_leds[7:4] == 4'hF))
        else $error("bad status LED pattern");

endmodule

bind seven_segment_mode_display_scanner ssmds_checker u_ssmds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digit_enable (digit_enable),
    .segments     (segments),
    .status_leds  (status_leds)
);

[tb/tb_seven_segment_mode_display_scanner.sv]
// Testbench for seven_segment_mode_display_scanner: directed and random refresh ticks,
// each result checked against a built-in scan predictor. Depends on ssmds_pkg and the RTL.
`timescale 1ns / 1ps

module tb_seven_segment_mode_display_scanner;

    // One scanned digit plus the LED pattern, as the block reports it
    typedef struct packed {
        logic [7:0] digit_enable;
        logic [7:0] segments;
        logic [7:0] status_leds;
    } scan_out_t;

    // Active-low status LED masks
    localparam logic [7:0] LED_DAC_FLAG = 8'h01;
    localparam logic [7:0] LED_TEMP     = 8'h02;
    localparam logic [7:0] LED_PARAM    = 8'h04;
    localparam logic [7:0] LED_DAC      = 8'h08;

    // Cycles with no request and no result accepted before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_TICKS = 184;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [13:0] temperature = '0;
    logic [6:0]  setpoint = '0;
    logic [13:0] dac_millivolts = '0;
    logic [1:0]  display_mode = ssmds_pkg::MODE_KEEP;
    logic        dac_follows_mode = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  digit_enable;
    logic [7:0]  segments;
    logic [7:0]  status_leds;

    // Predictor state: scan position and the active-low segment buffer
    logic [2:0]  scan_pos;
    logic [7:0]  shown [8];

    scan_out_t   pending_scans [$];
    int          snd_idle_pct = 31;
    int          rcv_idle_pct = 57;
    int          err_count = 0;
    int          scans_checked = 0;
    int          ticks_sent = 0;
    int          mode_count [4] = '{0, 0, 0, 0};
    int          quiet_cycles = 0;

    seven_segment_mode_display_scanner dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .temperature      (temperature),
        .setpoint         (setpoint),
        .dac_millivolts   (dac_millivolts),
        .display_mode     (display_mode),
        .dac_follows_mode (dac_follows_mode),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .digit_enable     (digit_enable),
        .segments         (segments),
        .status_leds      (status_leds)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------

    // Active-low segment pattern of one decimal digit
    function automatic logic [7:0] seg_for_digit(input int unsigned d);
        case (d)
            0:       return 8'hC0;
            1:       return 8'hF9;
            2:       return 8'hA4;
            3:       return 8'hB0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hF8;
            8:       return 8'h80;
            default: return 8'h90;
        endcase
    endfunction

    // Digit at the given decimal weight; values above range simply wrap per digit
    function automatic logic [7:0] place_seg(input int unsigned v, input int unsigned weight);
        return seg_for_digit((v / weight) % 10);
    endfunction

    // Refresh the buffer for this tick, then read out the scanned digit.
    // The buffer is rewritten before the read, so the new content shows at once.
    function automatic scan_out_t predict_tick(input logic [13:0] t, input logic [6:0] sp,
                                               input logic [13:0] dac,
                                               input ssmds_pkg::mode_t m,
                                               input logic flag);
        scan_out_t   r;
        logic [7:0]  leds;
        int unsigned tv;
        int unsigned spv;
        int unsigned dv;
        tv  = 32'(t);
        spv = 32'(sp);
        dv  = 32'(dac);
        if (m != ssmds_pkg::MODE_KEEP)
        begin
            for (int k = 1; k < 8; k++)
                shown[k] = ssmds_pkg::SEG_BLANK;
        end
        case (m)
            ssmds_pkg::MODE_TEMP:
            begin
                // C, three blanks, XX.XX
                shown[0] = ssmds_pkg::SEG_LETTER_C;
                shown[4] = place_seg(tv, 1000);
                shown[5] = place_seg(tv, 100) & ssmds_pkg::SEG_DP_MASK;
                shown[6] = place_seg(tv, 10);
                shown[7] = place_seg(tv, 1);
            end
            ssmds_pkg::MODE_PARAM:
            begin
                // P, five blanks, two setpoint digits
                shown[0] = ssmds_pkg::SEG_LETTER_P;
                shown[6] = place_seg(spv, 10);
                shown[7] = place_seg(spv, 1);
            end
            ssmds_pkg::MODE_DAC:
            begin
                // P, four blanks, X.XX volts; the millivolt digit is not shown
                shown[0] = ssmds_pkg::SEG_LETTER_P;
                shown[5] = place_seg(dv, 1000) & ssmds_pkg::SEG_DP_MASK;
                shown[6] = place_seg(dv, 100);
                shown[7] = place_seg(dv, 10);
            end
            default: ;
        endcase

        leds = ssmds_pkg::LED_ALL_OFF;
        if (!flag)
            leds &= ~LED_DAC_FLAG;
        case (m)
            ssmds_pkg::MODE_TEMP:  leds &= ~LED_TEMP;
            ssmds_pkg::MODE_PARAM: leds &= ~LED_PARAM;
            ssmds_pkg::MODE_DAC:   leds &= ~LED_DAC;
            default:    ;
        endcase

        r.digit_enable = 8'h01 << scan_pos;
        r.segments     = shown[scan_pos];
        r.status_leds  = leds;
        scan_pos       = scan_pos + 3'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, checker and watchdog
    // ------------------------------------------------------------------

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rcv_idle_pct);

    // Every accepted result is matched against the oldest predicted scan.
    // The watchdog counts edges at which neither channel moves anything.
    always @(posedge clk)
    begin : check_results
        scan_out_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results still expected",
                         $realtime, pending_scans.size());
                $display("tb_seven_segment_mode_display_scanner: FAIL");
                $finish;
            end
            else if (out_valid && !out_stall)
            begin
                if (pending_scans.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result: enable %h segments %h leds %h",
                             $realtime, digit_enable, segments, status_leds);
                end
                else
                begin
                    want = pending_scans.pop_front();
                    scans_checked++;
                    if (digit_enable !== want.digit_enable)
                    begin
                        err_count++;
                        $display("%0t: digit_enable expected %h actual %h",
                                 $realtime, want.digit_enable, digit_enable);
                    end
                    if (segments !== want.segments)
                    begin
                        err_count++;
                        $display("%0t: segments expected %h actual %h",
                                 $realtime, want.segments, segments);
                    end
                    if (status_leds !== want.status_leds)
                    begin
                        err_count++;
                        $display("%0t: status_leds expected %h actual %h",
                                 $realtime, want.status_leds, status_leds);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one refresh tick at the falling edge, hold it until accepted, then
    // queue its predicted scan. Valid stays high if the next tick follows at once.
    task automatic send_tick(input logic [13:0] t, input logic [6:0] sp,
                             input logic [13:0] dac, input ssmds_pkg::mode_t m,
                             input logic flag);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        temperature      <= t;
        setpoint         <= sp;
        dac_millivolts   <= dac;
        display_mode     <= m;
        dac_follows_mode <= flag;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_scans.push_back(predict_tick(t, sp, dac, m, flag));
        mode_count[m]++;
        ticks_sent++;
    endtask

    // Stop sending and let every predicted scan come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Keep mode straight out of reset: the buffer is still all blank
    task automatic test_blank_after_reset();
        send_tick(14'd1234, 7'd56, 14'd7890, ssmds_pkg::MODE_KEEP, 1'b0);
        send_tick(14'h3FFF, 7'h7F, 14'h3FFF, ssmds_pkg::MODE_KEEP, 1'b1);
        send_tick(14'd0,    7'd0,  14'd0,    ssmds_pkg::MODE_KEEP, 1'b0);
        send_tick(14'd9999, 7'd99, 14'd9999, ssmds_pkg::MODE_KEEP, 1'b1);
    endtask

    // Scan sits at digits 4..7, 0 here, so all temperature digits show up
    task automatic test_temperature();
        send_tick(14'd0,     7'd0,  14'd0, ssmds_pkg::MODE_TEMP, 1'b0);
        send_tick(14'd9999,  7'd0,  14'd0, ssmds_pkg::MODE_TEMP, 1'b1);
        send_tick(14'd1234,  7'd0,  14'd0, ssmds_pkg::MODE_TEMP, 1'b0);
        send_tick(14'h3FFF,  7'h7F, 14'h3FFF, ssmds_pkg::MODE_TEMP, 1'b1);  // above range
        send_tick(14'd5678,  7'd0,  14'd0, ssmds_pkg::MODE_TEMP, 1'b1);
    endtask

    // Parameter mode over scan digits 1..7, in and above range
    task automatic test_setpoint();
        send_tick(14'd0,    7'd0,   14'd0, ssmds_pkg::MODE_PARAM, 1'b1);
        send_tick(14'd0,    7'd99,  14'd0, ssmds_pkg::MODE_PARAM, 1'b0);
        send_tick(14'h3FFF, 7'd127, 14'd0, ssmds_pkg::MODE_PARAM, 1'b1);
        send_tick(14'd0,    7'd55,  14'd0, ssmds_pkg::MODE_PARAM, 1'b0);
        send_tick(14'd0,    7'd127, 14'd0, ssmds_pkg::MODE_PARAM, 1'b1);
        send_tick(14'd0,    7'd99,  14'd0, ssmds_pkg::MODE_PARAM, 1'b0);
        send_tick(14'd0,    7'd0,   14'h3FFF, ssmds_pkg::MODE_PARAM, 1'b1);
    endtask

    // DAC mode fills the buffer; keep mode then scans the held digits out
    // while its own inputs change and must be ignored
    task automatic test_dac_then_keep();
        send_tick(14'd0, 7'd0, 14'd0,    ssmds_pkg::MODE_DAC, 1'b0);
        send_tick(14'd0, 7'd0, 14'd9999, ssmds_pkg::MODE_DAC, 1'b1);
        send_tick(14'd0, 7'd0, 14'h3FFF, ssmds_pkg::MODE_DAC, 1'b0);  // above range
        send_tick(14'd0, 7'd0, 14'd5678, ssmds_pkg::MODE_DAC, 1'b1);
        send_tick(14'd1111, 7'd11, 14'd2222, ssmds_pkg::MODE_KEEP, 1'b1);
        send_tick(14'h3FFF, 7'h7F, 14'h3FFF, ssmds_pkg::MODE_KEEP, 1'b0);
        send_tick(14'd0,    7'd0,  14'd0,    ssmds_pkg::MODE_KEEP, 1'b1);
        send_tick(14'd4321, 7'd43, 14'd8765, ssmds_pkg::MODE_KEEP, 1'b0);
    endtask

    // Mostly in-range values, a quarter of them spanning the full field width
    function automatic int unsigned pick_value(input int unsigned max_in_range,
                                               input int unsigned max_raw);
        if ($urandom_range(3) == 0)
            return $urandom_range(max_raw);
        return $urandom_range(max_in_range);
    endfunction

    task automatic test_random_ticks(input int n, input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (n)
            send_tick(14'(pick_value(9999, 16383)), 7'(pick_value(99, 127)),
                      14'(pick_value(9999, 16383)),
                      ssmds_pkg::mode_t'($urandom_range(3)),
                      1'($urandom_range(1)));
        // Sender holds off until every scan of this phase is back
        wait_drained();
    endtask

    initial
    begin
        scan_pos = '0;
        for (int k = 0; k < 8; k++)
            shown[k] = ssmds_pkg::SEG_BLANK;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_blank_after_reset();
        test_temperature();
        test_setpoint();
        test_dac_then_keep();
        test_random_ticks(PHASE_TICKS, 31, 57);
        test_random_ticks(PHASE_TICKS, 57, 31);
        test_random_ticks(PHASE_TICKS, 0, 0);

        $display("Covered %0d refresh ticks (temp %0d, param %0d, dac %0d, keep %0d),",
                 ticks_sent, mode_count[ssmds_pkg::MODE_TEMP],
                 mode_count[ssmds_pkg::MODE_PARAM],
                 mode_count[ssmds_pkg::MODE_DAC], mode_count[ssmds_pkg::MODE_KEEP]);
        $display("%0d scans checked under mixed idling, %0d mismatches.",
                 scans_checked, err_count);
        if (err_count == 0 && pending_scans.size() == 0)
            $display("tb_seven_segment_mode_display_scanner: PASS");
        else
            $display("tb_seven_segment_mode_display_scanner: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/ssmds_pkg.sv
rtl/seven_segment_mode_display_scanner.sv
rtl/ssmds_checker.sv
tb/tb_seven_segment_mode_display_scanner.sv
